// ===== rtl/i2fdq_pkg.sv =====
// Package for the int32-to-float dequantizer: widths, register indexes,
// IEEE single helpers and the lane control struct. No dependencies.
`default_nettype none
package i2fdq_pkg;
    localparam int CHANNELS_DEF = 256;
    localparam int LANES_DEF = 4;
    localparam int OUT_LANES = 4;
    localparam int WORD_W = 32;
    localparam int CH_W = 8;
    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;

    typedef enum logic [1:0] {
        REG_PER_CH = 2'd0,
        REG_BIAS_MODE = 2'd1,
        REG_SCALE = 2'd2,
        REG_BIAS = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic bias_on;
    } lane_ctl_t;

    // Round-to-nearest-even pack of a normalized magnitude.
    // sig holds the leading one at bit 47 (value = sig * 2^(exp - 47 - 127)).
    // exp is the biased exponent of the leading bit, may be <= 0 or large.
    function automatic logic [31:0] fp_pack(input logic sgn, input logic signed [11:0] exp,
                                            input logic [47:0] sig);
        logic [47:0] s;
        logic signed [11:0] e;
        logic [11:0] sh;
        logic [24:0] m;
        logic g;
        logic st;
        logic [31:0] r;
        begin
            s = sig;
            e = exp;
            if (e < 12'sd1)
            begin
                sh = 12'(12'sd1 - e);
                if (sh > 12'd48)
                    s = {47'd0, |sig};
                else
                    s = (sig >> sh) | {47'd0, |(sig & ~({48{1'b1}} << sh))};
                e = 12'sd0;
            end
            m = {1'b0, s[47:24]};
            g = s[23];
            st = |s[22:0];
            if (g && (st || m[0]))
                m = m + 25'd1;
            if (e == 12'sd0)
            begin
                if (m[23])
                    e = 12'sd1;
            end
            else if (m[24])
            begin
                m = m >> 1;
                e = e + 12'sd1;
            end
            if (e >= 12'sd255)
                r = {sgn, 8'hFF, 23'd0};
            else
                r = {sgn, e[7:0], m[22:0]};
            fp_pack = r;
        end
    endfunction

    // Leading-zero count of a 48-bit word (normalization shift count), 48 for zero.
    function automatic logic [5:0] lz48(input logic [47:0] v);
        logic [5:0] n;
        begin
            n = 6'd48;
            for (int i = 0; i < 48; i++)
            begin
                if (v[i])
                    n = 6'(47 - i);
            end
            lz48 = n;
        end
    endfunction
endpackage
`default_nettype wire

// ===== rtl/i2fdq_lane.sv =====
// One lane: int32 to float, multiply by scale, add bias if enabled, in three registered stages.
// Depends on i2fdq_pkg.
`default_nettype none
module i2fdq_lane
(
    input  wire logic                  clk,
    input  wire logic                  adv,
    input  wire logic signed [31:0]    value,
    input  wire logic [31:0]           scale,
    input  wire logic [31:0]           bias,
    input  wire logic                  bias_on,
    output logic [31:0]                result
);
    import i2fdq_pkg::*;

    // Stage 1: conversion, with scale and bias carried along.
    logic [31:0] x_reg, x_next, s1_reg, b1_reg, b2_reg, p_reg, p_next, r_reg, r_next;
    logic on1_reg, on2_reg;
    logic [31:0] mag;
    logic [47:0] nsig;

    always_comb
    begin
        mag = value[31] ? 32'(-value) : 32'(value);
        nsig = {mag, 16'd0} << lz48({mag, 16'd0});
        if (mag == 32'd0)
            x_next = 32'd0;
        else
            x_next = fp_pack(value[31], 12'(12'sd127 + 12'sd47 - 12'(lz48({mag, 16'd0}))
                                       - 12'sd16), nsig);
    end

    // Stage 2: multiply.
    logic ps;
    logic [7:0] xe, se;
    logic [23:0] xm, sm;
    logic [47:0] prod, pn;
    logic [5:0] lzp;
    always_comb
    begin
        ps = x_reg[31] ^ s1_reg[31];
        xe = x_reg[30:23];
        se = s1_reg[30:23];
        xm = {xe != 8'd0, x_reg[22:0]};
        sm = {se != 8'd0, s1_reg[22:0]};
        prod = xm * sm;
        lzp = lz48(prod);
        pn = prod << lzp;
        if ((xe == 8'hFF && x_reg[22:0] != 23'd0) || (se == 8'hFF && s1_reg[22:0] != 23'd0))
            p_next = QNAN_BITS;
        else if (xe == 8'hFF || se == 8'hFF)
        begin
            if ((xe == 8'hFF && s1_reg[30:0] == 31'd0) || (se == 8'hFF && x_reg[30:0] == 31'd0))
                p_next = QNAN_BITS;
            else
                p_next = {ps, 8'hFF, 23'd0};
        end
        else if (prod == 48'd0)
            p_next = {ps, 31'd0};
        else
            p_next = fp_pack(ps, 12'(12'({4'd0, xe}) + 12'(xe == 8'd0) + 12'({4'd0, se})
                             + 12'(se == 8'd0) - 12'sd127 + 12'sd1 - 12'({6'd0, lzp})), pn);
    end

    // Stage 3: add.
    logic [7:0] ae, be, ea, eb;
    logic [47:0] ma, mb, sa, sb, sum, sn;
    logic [8:0] d;
    logic [5:0] lzs;
    logic big_a, rs;
    logic [31:0] a, b;
    always_comb
    begin
        a = p_reg;
        b = b2_reg;
        ae = a[30:23];
        be = b[30:23];
        r_next = a;
        ma = 48'd0; mb = 48'd0; sa = 48'd0; sb = 48'd0; sum = 48'd0; sn = 48'd0;
        d = 9'd0; lzs = 6'd0; big_a = 1'b0; rs = 1'b0; ea = 8'd0; eb = 8'd0;
        if (on2_reg)
        begin
            if ((ae == 8'hFF && a[22:0] != 23'd0) || (be == 8'hFF && b[22:0] != 23'd0))
                r_next = QNAN_BITS;
            else if (ae == 8'hFF && be == 8'hFF)
                r_next = (a[31] == b[31]) ? a : QNAN_BITS;
            else if (ae == 8'hFF)
                r_next = a;
            else if (be == 8'hFF)
                r_next = b;
            else
            begin
                ea = (ae == 8'd0) ? 8'd1 : ae;
                eb = (be == 8'd0) ? 8'd1 : be;
                big_a = (a[30:0] >= b[30:0]);
                ma = {1'b0, ae != 8'd0, a[22:0], 23'd0};
                mb = {1'b0, be != 8'd0, b[22:0], 23'd0};
                if (big_a)
                begin
                    d = {1'b0, ea} - {1'b0, eb};
                    sa = ma;
                    sb = (d > 9'd47) ? {47'd0, |mb} : ((mb >> d) | {47'd0, |(mb & ~({48{1'b1}} << d))});
                    rs = a[31];
                end
                else
                begin
                    d = {1'b0, eb} - {1'b0, ea};
                    sa = mb;
                    sb = (d > 9'd47) ? {47'd0, |ma} : ((ma >> d) | {47'd0, |(ma & ~({48{1'b1}} << d))});
                    rs = b[31];
                    ea = eb;
                end
                sum = (a[31] == b[31]) ? sa + sb : sa - sb;
                lzs = lz48(sum);
                sn = sum << lzs;
                if (sum == 48'd0)
                    r_next = {a[31] & b[31], 31'd0};
                else
                    r_next = fp_pack(rs, 12'(12'({4'd0, ea}) + 12'sd1 - 12'({6'd0, lzs})), sn);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg <= x_next;
            s1_reg <= scale;
            b1_reg <= bias;
            on1_reg <= bias_on;
            p_reg <= p_next;
            b2_reg <= b1_reg;
            on2_reg <= on1_reg;
            r_reg <= r_next;
        end
    end

    assign result = (r_reg[30:23] == 8'hFF && r_reg[22:0] != 23'd0) ? QNAN_BITS : r_reg;
endmodule
`default_nettype wire

// ===== rtl/i2fdq_table.sv =====
// Per-channel scale and bias memory, one write port and one registered read per lane.
// Depends on i2fdq_pkg.
`default_nettype none
module i2fdq_table
#(
    parameter int CHANNELS = i2fdq_pkg::CHANNELS_DEF,
    parameter int LANES = i2fdq_pkg::LANES_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            we,
    input  wire logic [$clog2(CHANNELS+1)-1:0]   waddr,
    input  wire logic [63:0]                     wdata,
    input  wire logic                            re,
    input  wire logic [LANES-1:0][$clog2(CHANNELS+1)-1:0] raddr,
    output logic [LANES-1:0][63:0]               rdata
);
    import i2fdq_pkg::*;
    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // One copy per lane keeps each copy at one write and one read port.
    for (genvar j = 0; j < LANES; j++)
    begin : g_bank
        logic [63:0] mem [CHANNELS];
        always_ff @(posedge clk)
        begin
            if (we)
                mem[waddr[AW-1:0]] <= wdata;
            if (re)
                rdata[j] <= mem[raddr[j][AW-1:0]];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/int32_to_float_dequantize.sv =====
// Top level of the int32-to-float dequantizer: APB registers, channel table,
// four lanes and the output register. Depends on i2fdq_pkg, i2fdq_table, i2fdq_lane.
//
// Channel  | Dir | Handshake           | Contents
// s_axis   | in  | tvalid/tready       | tuser=req_type, tdata=channel..entry_bias, tlast=in_last
// m_axis   | out | tvalid/tready       | tdata=out0..out3, tlast=out_last
// apb      | in  | psel/penable/pready | four registers
// One item per cycle while the pipeline is not stalled; a data word passes the
// table read, conversion, multiply, add and output register stages in turn.
// The pipeline advances as a whole; it stalls only when the output register
// holds an untaken word and stage three also holds one.
// Reset clears the valid bits and the APB registers; the tables and data registers are not cleared.
`default_nettype none
module int32_to_float_dequantize
#(
    parameter int CHANNELS = i2fdq_pkg::CHANNELS_DEF,
    parameter int LANES = i2fdq_pkg::LANES_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // channel[7:0], packed_req[8], value0..3[136:9], entry_scale[168:137],
    // entry_bias[200:169], zero fill to 208
    input  wire logic [207:0] s_axis_tdata,
    // req_type
    input  wire logic         s_axis_tuser,
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // out0[31:0], out1[63:32], out2[95:64], out3[127:96]
    output logic [127:0]      m_axis_tdata,
    output logic              m_axis_tlast,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import i2fdq_pkg::*;
    localparam int IW = $clog2(CHANNELS + 1);
    localparam int NL = (LANES < OUT_LANES) ? LANES : OUT_LANES;

    logic per_ch_reg;
    logic [1:0] bias_mode_reg;
    logic [31:0] scale_reg, bias_reg;
    reg_idx_t ridx;
    logic wr;

    assign pready = 1'b1;
    assign ridx = reg_idx_t'(paddr[3:2]);
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            per_ch_reg <= 1'b0;
            bias_mode_reg <= 2'd0;
            scale_reg <= SCALE_RESET;
            bias_reg <= 32'd0;
        end
        else if (wr)
        begin
            case (ridx)
                REG_PER_CH:    per_ch_reg <= pwdata[0];
                REG_BIAS_MODE: bias_mode_reg <= pwdata[1:0];
                REG_SCALE:     scale_reg <= pwdata;
                REG_BIAS:      bias_reg <= pwdata;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            REG_PER_CH:    prdata = {31'd0, per_ch_reg};
            REG_BIAS_MODE: prdata = {30'd0, bias_mode_reg};
            REG_SCALE:     prdata = scale_reg;
            REG_BIAS:      prdata = bias_reg;
            default:       prdata = 32'd0;
        endcase
    end

    // Pipeline control: stage 0 table read, 1..3 lanes, 4 output register.
    lane_ctl_t ctl_reg [4];
    logic out_valid_reg, out_last_reg;
    logic [127:0] out_data_reg;
    logic adv, acc, data_acc, load_acc;

    assign adv = !out_valid_reg || m_axis_tready || !ctl_reg[3].valid;
    assign s_axis_tready = adv;
    assign acc = s_axis_tvalid && adv;
    assign data_acc = acc && s_axis_tuser;
    assign load_acc = acc && !s_axis_tuser;

    logic [LANES-1:0][IW-1:0] raddr;
    logic [LANES-1:0][63:0] rdata;
    logic [LANES-1:0][31:0] v0_reg;
    logic [IW-1:0] ch_w;
    assign ch_w = IW'(s_axis_tdata[7:0] % CHANNELS);

    for (genvar j = 0; j < LANES; j++)
    begin : g_addr
        logic [IW+3:0] sum;
        assign sum = (IW+4)'(s_axis_tdata[7:0]) + (s_axis_tdata[8] ? (IW+4)'(j) : '0);
        assign raddr[j] = IW'(sum % CHANNELS);
        always_ff @(posedge clk)
        begin
            if (adv)
                v0_reg[j] <= (j < OUT_LANES) ? s_axis_tdata[9 + 32*(j % OUT_LANES) +: 32] : 32'd0;
        end
    end

    i2fdq_table #(.CHANNELS(CHANNELS), .LANES(LANES)) u_table
    (
        .clk   (clk),
        .we    (load_acc),
        .waddr (ch_w),
        .wdata ({s_axis_tdata[200:169], s_axis_tdata[168:137]}),
        .re    (adv),
        .raddr (raddr),
        .rdata (rdata)
    );

    logic per0_reg;
    logic [1:0] bm0_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            per0_reg <= per_ch_reg;
            bm0_reg <= bias_mode_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                ctl_reg[i] <= '0;
        end
        else if (adv)
        begin
            ctl_reg[0] <= '{valid: data_acc, last: s_axis_tlast, bias_on: 1'b0};
            ctl_reg[1] <= ctl_reg[0];
            ctl_reg[2] <= ctl_reg[1];
            ctl_reg[3] <= ctl_reg[2];
        end
    end

    logic [OUT_LANES-1:0][31:0] res;
    for (genvar j = 0; j < OUT_LANES; j++)
    begin : g_lane
        if (j < NL)
        begin : g_on
            i2fdq_lane u_lane
            (
                .clk     (clk),
                .adv     (adv),
                .value   (v0_reg[j]),
                .scale   (per0_reg ? rdata[j][31:0] : scale_reg),
                .bias    (bm0_reg[1] ? rdata[j][63:32] : bias_reg),
                .bias_on (bm0_reg != 2'd0),
                .result  (res[j])
            );
        end
        else
        begin : g_off
            assign res[j] = 32'd0;
        end
    end

    // Merge the lane results into one output word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv && ctl_reg[3].valid)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && ctl_reg[3].valid)
        begin
            out_data_reg <= res;
            out_last_reg <= ctl_reg[3].last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
    assign m_axis_tlast = out_last_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg)
        else $error("output word dropped while stalled");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |-> out_valid_reg && ctl_reg[3].valid)
        else $error("stall without a waiting word");
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        load_acc |=> !ctl_reg[0].valid)
        else $error("table load entered the data pipeline");
endmodule
`default_nettype wire
